// File: rtl/core/assert_macros.svh
// Assertion macros for the filename checker RTL.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks prop at every rising edge of clk, disabled while rst is high.
`define FSC_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Same check, but with no reset qualifier; it holds during reset as well.
`define FSC_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: rtl/core/fsc_pkg.sv
`timescale 1ns / 1ps
// Package for the filename safety checker: widths, character codes,
// history cell control type and register map. No dependencies.
package fsc_pkg;

   localparam int CharWidth     = 8;
   localparam int HistDepth     = 3;
   localparam int CsrAddrWidth  = 2;
   localparam int CsrDataWidth  = 32;

   localparam logic [CharWidth-1:0] MaxLenReset = 8'd50;
   localparam logic [CharWidth-1:0] MaxLenCap   = 8'd254;
   localparam logic [CharWidth-1:0] MaxLenRaw   = 8'd255;
   localparam logic [CharWidth-1:0] CountSat    = 8'd255;

   // register index (word address)
   localparam logic [CsrAddrWidth-1:0] RegMaxNameLength = '0;

   localparam logic [CharWidth-1:0] ChDot   = 8'h2E;
   localparam logic [CharWidth-1:0] ChDash  = 8'h2D;
   localparam logic [CharWidth-1:0] ChUnder = 8'h5F;
   localparam logic [CharWidth-1:0] ChLowA  = 8'h61;
   localparam logic [CharWidth-1:0] ChLowZ  = 8'h7A;
   localparam logic [CharWidth-1:0] ChUpA   = 8'h41;
   localparam logic [CharWidth-1:0] ChUpZ   = 8'h5A;
   localparam logic [CharWidth-1:0] Ch0     = 8'h30;
   localparam logic [CharWidth-1:0] Ch9     = 8'h39;
   localparam logic [CharWidth-1:0] ChLowE  = 8'h65;
   localparam logic [CharWidth-1:0] ChLowX  = 8'h78;
   localparam logic [CharWidth-1:0] ChLowB  = 8'h62;
   localparam logic [CharWidth-1:0] ChLowT  = 8'h74;
   localparam logic [CharWidth-1:0] ChLowS  = 8'h73;
   localparam logic [CharWidth-1:0] ChLowH  = 8'h68;
   localparam logic [CharWidth-1:0] ChUpE   = 8'h45;
   localparam logic [CharWidth-1:0] ChUpX   = 8'h58;
   localparam logic [CharWidth-1:0] ChUpB   = 8'h42;
   localparam logic [CharWidth-1:0] ChUpT   = 8'h54;
   localparam logic [CharWidth-1:0] ChUpS   = 8'h53;
   localparam logic [CharWidth-1:0] ChUpH   = 8'h48;

   // control broadcast to every history cell
   typedef struct packed {
      logic shift;
      logic clear;
   } hist_ctl_type;

endpackage

// File: rtl/core/fsc_hist_cell.sv
`timescale 1ns / 1ps
// One cell of the character history chain: holds one byte and passes it on.
// Depends on fsc_pkg.
module fsc_hist_cell (
   input  logic                          clock,
   input  logic                          reset,
   input  fsc_pkg::hist_ctl_type         ctl,
   input  logic [fsc_pkg::CharWidth-1:0] char_from_prev,
   output logic [fsc_pkg::CharWidth-1:0] char_out
);

   logic [fsc_pkg::CharWidth-1:0] char_ff;
   logic [fsc_pkg::CharWidth-1:0] char_in;

   // clear wins: the name ends on this transaction
   always_comb begin
      char_in = char_ff;
      if (ctl.clear) begin
         char_in = '0;
      end else if (ctl.shift) begin
         char_in = char_from_prev;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         char_ff <= '0;
      end else begin
         char_ff <= char_in;
      end
   end

   assign char_out = char_ff;

endmodule

// File: rtl/core/fsc_csr.sv
`timescale 1ns / 1ps
// APB-style register block holding max_name_length.
// Depends on fsc_pkg.
module fsc_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [fsc_pkg::CsrAddrWidth-1:0] paddr,
   input  logic [fsc_pkg::CsrDataWidth-1:0] pwdata,
   output logic [fsc_pkg::CsrDataWidth-1:0] prdata,
   output logic                             pready,
   output logic [fsc_pkg::CharWidth-1:0]    max_len
);

   logic [fsc_pkg::CharWidth-1:0] max_len_ff;
   logic [fsc_pkg::CharWidth-1:0] max_len_in;
   logic                          wr_en;

   // single register at word address 0
   assign wr_en = psel && penable && pwrite && (paddr == fsc_pkg::RegMaxNameLength);

   always_comb begin
      max_len_in = max_len_ff;
      if (wr_en) begin
         max_len_in = pwdata[fsc_pkg::CharWidth-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff <= fsc_pkg::MaxLenReset;
      end else begin
         max_len_ff <= max_len_in;
      end
   end

   assign prdata  = {{(fsc_pkg::CsrDataWidth-fsc_pkg::CharWidth){1'b0}}, max_len_ff};
   assign pready  = 1'b1;
   assign max_len = max_len_ff;

endmodule

// File: rtl/core/filename_safety_checker_top.sv
`timescale 1ns / 1ps
// Filename safety checker: at most one character per transaction, verdict on the last.
// The verdict is registered on rsp_ in the cycle after the last transaction is taken.
// Throughput: one character per cycle, but a last transaction stalls while a held verdict waits.
// Reset: synchronous, active high; clears count, history, reject flag and
// rsp_valid, and loads max_name_length with 50. No clearing pass.
// Depends on fsc_pkg, fsc_hist_cell, fsc_csr and assert_macros.svh.
`include "assert_macros.svh"

module filename_safety_checker_top (
   input  logic                             clock,
   input  logic                             reset,
   // character transactions
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [fsc_pkg::CharWidth-1:0]    req_char_code,
   input  logic                             req_char_present,
   input  logic                             req_is_last,
   // verdict transactions
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic                             rsp_name_safe,
   // configuration
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [fsc_pkg::CsrAddrWidth-1:0] paddr,
   input  logic [fsc_pkg::CsrDataWidth-1:0] pwdata,
   output logic [fsc_pkg::CsrDataWidth-1:0] prdata,
   output logic                             pready
);

   localparam int W = fsc_pkg::CharWidth;
   localparam int D = fsc_pkg::HistDepth;

   logic [W-1:0] max_len;

   fsc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .max_len (max_len)
   );

   // ---------------------------------------------------------------
   // Handshake. Only a last transaction produces a verdict, so only
   // that one has to wait while the output register is held.
   // Everything else flows in even with a verdict pending.
   // ---------------------------------------------------------------
   logic rsp_valid_ff, rsp_valid_in;
   logic name_safe_ff, name_safe_in;
   logic req_take, take_char, take_last;

   assign req_stall = rsp_valid_ff && rsp_stall && req_is_last;
   assign req_take  = req_valid && !req_stall;
   assign take_char = req_take && req_char_present;
   assign take_last = req_take && req_is_last;

   // ---------------------------------------------------------------
   // History chain: cell 0 holds the newest character, each cell
   // hands its byte to the next one on every character transaction but a last one.
   // ---------------------------------------------------------------
   fsc_pkg::hist_ctl_type hist_ctl;
   logic [W-1:0]          hist [D+1];

   assign hist_ctl.shift = take_char;
   assign hist_ctl.clear = take_last;
   assign hist[0]        = req_char_code;

   for (genvar g = 0; g < D; g++) begin : g_hist
      fsc_hist_cell u_cell (
         .clock          (clock),
         .reset          (reset),
         .ctl            (hist_ctl),
         .char_from_prev (hist[g]),
         .char_out       (hist[g+1])
      );
   end

   // p0 newest, p2 oldest
   logic [W-1:0] c, p0, p1, p2;
   assign c  = req_char_code;
   assign p0 = hist[1];
   assign p1 = hist[2];
   assign p2 = hist[3];

   // ---------------------------------------------------------------
   // Character checks
   // ---------------------------------------------------------------
   logic char_ok, bad_seq;

   always_comb begin
      char_ok = ((c >= fsc_pkg::ChLowA) && (c <= fsc_pkg::ChLowZ)) ||
                ((c >= fsc_pkg::ChUpA)  && (c <= fsc_pkg::ChUpZ))  ||
                ((c >= fsc_pkg::Ch0)    && (c <= fsc_pkg::Ch9))    ||
                (c == fsc_pkg::ChDot) || (c == fsc_pkg::ChDash) ||
                (c == fsc_pkg::ChUnder);
   end

   // a forbidden substring ends on the incoming character
   always_comb begin
      bad_seq = 1'b0;
      if (p0 == fsc_pkg::ChDot && c == fsc_pkg::ChDot) begin
         bad_seq = 1'b1;
      end
      if (p1 == fsc_pkg::ChDot) begin
         if ((p0 == fsc_pkg::ChLowS && c == fsc_pkg::ChLowH) ||
             (p0 == fsc_pkg::ChUpS  && c == fsc_pkg::ChUpH)) begin
            bad_seq = 1'b1;
         end
      end
      if (p2 == fsc_pkg::ChDot) begin
         if ((p1 == fsc_pkg::ChLowE && p0 == fsc_pkg::ChLowX && c == fsc_pkg::ChLowE) ||
             (p1 == fsc_pkg::ChUpE  && p0 == fsc_pkg::ChUpX  && c == fsc_pkg::ChUpE)  ||
             (p1 == fsc_pkg::ChLowB && p0 == fsc_pkg::ChLowA && c == fsc_pkg::ChLowT) ||
             (p1 == fsc_pkg::ChUpB  && p0 == fsc_pkg::ChUpA  && c == fsc_pkg::ChUpT)) begin
            bad_seq = 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------
   // Length count (saturating) and sticky reject flag
   // ---------------------------------------------------------------
   logic [W-1:0] chars_seen_ff, chars_seen_in, count_upd, limit;
   logic         rejected_ff, rejected_in, reject_upd;

   // an all-ones limit behaves as the cap
   assign limit = (max_len == fsc_pkg::MaxLenRaw) ? fsc_pkg::MaxLenCap : max_len;

   always_comb begin
      count_upd  = chars_seen_ff;
      reject_upd = rejected_ff;
      if (take_char) begin
         if (chars_seen_ff != fsc_pkg::CountSat) begin
            count_upd = chars_seen_ff + 1'b1;
         end
         if ((chars_seen_ff == '0) && (c == fsc_pkg::ChDot)) begin
            reject_upd = 1'b1;
         end
         if (!char_ok || bad_seq || (count_upd > limit)) begin
            reject_upd = 1'b1;
         end
      end
   end

   always_comb begin
      chars_seen_in = count_upd;
      rejected_in   = reject_upd;
      if (take_last) begin
         chars_seen_in = '0;
         rejected_in   = 1'b0;
      end
   end

   // output register: loads on a last transaction, holds while stalled
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      name_safe_in = name_safe_ff;
      if (take_last) begin
         rsp_valid_in = 1'b1;
         name_safe_in = !reject_upd && (count_upd != '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chars_seen_ff <= '0;
         rejected_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         chars_seen_ff <= chars_seen_in;
         rejected_ff   <= rejected_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      name_safe_ff <= name_safe_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_name_safe = name_safe_ff;

   // ---------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------
   `FSC_ASSERT(a_clear_after_last, clock, reset, take_last |=> (chars_seen_ff == '0) && !rejected_ff && (p0 == '0), "name state not cleared after last transaction")
   `FSC_ASSERT(a_rsp_kept, clock, reset, (rsp_valid_ff && rsp_stall) |=> rsp_valid_ff, "pending verdict dropped")
   `FSC_ASSERT_ALWAYS(a_stall_only_last, clock, req_stall |-> (req_is_last && rsp_valid_ff), "input stalled without a pending verdict")
   `FSC_ASSERT(a_last_gives_rsp, clock, reset, take_last |=> rsp_valid_ff, "last transaction gave no verdict")

endmodule

// File: tb/sv/fsc_verdict_checker.sv
`timescale 1ns / 1ps
// Verdict checker for the filename safety checker: follows the character,
// verdict and register transactions, predicts each verdict and compares.
// Depends on fsc_pkg.
module fsc_verdict_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   input  logic                             req_stall,
   input  logic [fsc_pkg::CharWidth-1:0]    req_char_code,
   input  logic                             req_char_present,
   input  logic                             req_is_last,
   input  logic                             rsp_valid,
   input  logic                             rsp_stall,
   input  logic                             rsp_name_safe,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [fsc_pkg::CsrAddrWidth-1:0] paddr,
   input  logic [fsc_pkg::CsrDataWidth-1:0] pwdata,
   input  logic [fsc_pkg::CsrDataWidth-1:0] prdata,
   input  logic                             pready,
   output int                               fail_count,
   output int                               verdicts_due
);
   import fsc_pkg::*;

   typedef logic [CharWidth-1:0] char_type;

   char_type name_limit;
   char_type name_len;
   char_type recent [HistDepth];
   logic     name_bad;
   logic     verdict_q [$];
   logic     expected_safe;
   int       errors = 0;

   assign fail_count = errors;

   task automatic flag_mismatch(input string what);
      $display("%0t ns: MISMATCH %s", $realtime, what);
      errors++;
   endtask

   function automatic logic is_name_char(input char_type c);
      return (c >= ChLowA && c <= ChLowZ) || (c >= ChUpA && c <= ChUpZ) ||
             (c >= Ch0 && c <= Ch9) || c == ChDot || c == ChDash || c == ChUnder;
   endfunction

   // c closes one of the banned substrings, given the three before it
   function automatic logic ends_banned(input char_type c, input char_type p0,
                                        input char_type p1, input char_type p2);
      if (p0 == ChDot && c == ChDot) return 1'b1;
      if (p1 == ChDot && p0 == ChLowS && c == ChLowH) return 1'b1;
      if (p1 == ChDot && p0 == ChUpS && c == ChUpH) return 1'b1;
      if (p2 == ChDot) begin
         if (p1 == ChLowE && p0 == ChLowX && c == ChLowE) return 1'b1;
         if (p1 == ChUpE && p0 == ChUpX && c == ChUpE) return 1'b1;
         if (p1 == ChLowB && p0 == ChLowA && c == ChLowT) return 1'b1;
         if (p1 == ChUpB && p0 == ChUpA && c == ChUpT) return 1'b1;
      end
      return 1'b0;
   endfunction

   task automatic take_char(input char_type c);
      char_type cap;
      cap = (name_limit > MaxLenCap) ? MaxLenCap : name_limit;
      if (name_len == 0 && c == ChDot) name_bad = 1'b1;
      if (!is_name_char(c)) name_bad = 1'b1;
      if (ends_banned(c, recent[0], recent[1], recent[2])) name_bad = 1'b1;
      if (name_len != CountSat) name_len = name_len + 1'b1;
      if (name_len > cap) name_bad = 1'b1;
      recent[2] = recent[1];
      recent[1] = recent[0];
      recent[0] = c;
   endtask

   task automatic clear_name();
      name_len = '0;
      name_bad = 1'b0;
      foreach (recent[i]) recent[i] = '0;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         name_limit = MaxLenReset;
         clear_name();
         verdict_q.delete();
      end else begin
         // verdict first: one taken at this edge belongs to an older name
         if (rsp_valid && !rsp_stall) begin
            if (verdict_q.size() == 0) begin
               flag_mismatch($sformatf("verdict %b with none outstanding", rsp_name_safe));
            end else begin
               expected_safe = verdict_q.pop_front();
               if (rsp_name_safe !== expected_safe)
                  flag_mismatch($sformatf("name_safe %b, predicted %b",
                                          rsp_name_safe, expected_safe));
            end
         end
         if (req_valid && !req_stall) begin
            if (req_char_present) take_char(req_char_code);
            if (req_is_last) begin
               verdict_q.push_back(!name_bad && name_len != 0);
               clear_name();
            end
         end
         if (psel && penable && pready && paddr == RegMaxNameLength) begin
            if (pwrite) begin
               name_limit = pwdata[CharWidth-1:0];
            end else if (prdata[CharWidth-1:0] !== name_limit) begin
               flag_mismatch($sformatf("max_name_length reads %0d, predicted %0d",
                                       prdata[CharWidth-1:0], name_limit));
            end
         end
      end
      verdicts_due <= verdict_q.size();
   end

endmodule

// File: tb/sv/filename_safety_checker_top_test.sv
`timescale 1ns / 1ps
// Top of the filename safety checker testbench: clock, reset, character and
// register stimulus, verdict-side stalls and the final verdict.
// Depends on fsc_pkg, filename_safety_checker_top and fsc_verdict_checker.
module filename_safety_checker_top_test;
   import fsc_pkg::*;

   typedef logic [CharWidth-1:0] char_type;

   logic                    clock;
   logic                    reset;
   logic                    req_valid;
   logic                    req_stall;
   char_type                req_char_code;
   logic                    req_char_present;
   logic                    req_is_last;
   logic                    rsp_valid;
   logic                    rsp_stall;
   logic                    rsp_name_safe;
   logic                    psel;
   logic                    penable;
   logic                    pwrite;
   logic [CsrAddrWidth-1:0] paddr;
   logic [CsrDataWidth-1:0] pwdata;
   logic [CsrDataWidth-1:0] prdata;
   logic                    pready;

   int fail_count;
   int verdicts_due;

   // stimulus knobs and tallies
   int       gap_pct;       // chance in percent of an idle gap after a transaction
   bit       squeeze_go;    // asks the verdict side for its long hold-off
   bit       squeeze_done;
   char_type limit_now;     // max_name_length as last programmed
   int       sent_count;
   int       name_count;
   int       limit_count;

   // fragments spliced into random names: the banned ones and near misses
   string snippets [13] = '{".exe", ".EXE", ".bat", ".BAT", ".sh", ".SH", "..",
                            ".ex", ".eXe", ".Sh", ".bt", ".txt", "a.b"};

   filename_safety_checker_top dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_char_code    (req_char_code),
      .req_char_present (req_char_present),
      .req_is_last      (req_is_last),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_name_safe    (rsp_name_safe),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready)
   );

   fsc_verdict_checker verdict_watch (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_char_code    (req_char_code),
      .req_char_present (req_char_present),
      .req_is_last      (req_is_last),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_name_safe    (rsp_name_safe),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready),
      .fail_count       (fail_count),
      .verdicts_due     (verdicts_due)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Hard stop; a correct run finishes in a small fraction of this.
   initial begin
      #10ms;
      $display("filename_safety_checker_top_test failed");
      $finish;
   end

   // Verdict side: runs of stall and no stall of random length, mostly short.
   // Once asked, it holds rsp_stall high so the single verdict slot fills
   // and the block has to stall the character side.
   initial begin
      int r;
      int n;
      rsp_stall    = 1'b0;
      squeeze_done = 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (squeeze_go && !squeeze_done) begin
            squeeze_done = 1'b1;
            rsp_stall <= 1'b1;
            repeat (300) @(posedge clock);
         end else begin
            r = $urandom_range(0, 99);
            if (r < 45) begin
               rsp_stall <= 1'b0;
               n = $urandom_range(1, 6);
            end else if (r < 75) begin
               rsp_stall <= 1'b1;
               n = $urandom_range(1, 3);
            end else if (r < 90) begin
               rsp_stall <= 1'b0;      // a stretch with no stalling at all
               n = $urandom_range(15, 50);
            end else begin
               rsp_stall <= 1'b1;
               n = $urandom_range(8, 30);
            end
            repeat (n) @(posedge clock);
         end
      end
   end

   function automatic char_type any_alnum();
      int r;
      r = $urandom_range(0, 61);
      if (r < 26) return char_type'(ChLowA + r);
      if (r < 52) return char_type'(ChUpA + r - 26);
      return char_type'(Ch0 + r - 52);
   endfunction

   // One character transaction; returns at the edge that took it, or after
   // the idle gap that follows.
   task automatic send_char(input char_type code, input logic present, input logic last);
      int n;
      req_valid        <= 1'b1;
      req_char_code    <= code;
      req_char_present <= present;
      req_is_last      <= last;
      do @(posedge clock); while (req_stall);
      sent_count++;
      if ($urandom_range(0, 99) < gap_pct) begin
         n = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3) : $urandom_range(8, 30);
         req_valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   // Builds and sends one name. Clean names use only letters, digits, '-' and
   // '_', so that only the length decides; the others mix in dots, banned
   // fragments, near misses and bytes outside the allowed set.
   task automatic send_name(input int len, input bit clean);
      char_type chars [$];
      string    piece;
      int       r;
      bit       marker;
      while (chars.size() < len) begin
         r = $urandom_range(0, 99);
         if (clean) begin
            if (r < 90) chars.push_back(any_alnum());
            else if (r < 95) chars.push_back(ChDash);
            else chars.push_back(ChUnder);
         end else if (r < 55) begin
            chars.push_back(any_alnum());
         end else if (r < 63) begin
            chars.push_back(ChDot);
         end else if (r < 67) begin
            chars.push_back(ChDash);
         end else if (r < 71) begin
            chars.push_back(ChUnder);
         end else if (r < 83) begin
            piece = snippets[$urandom_range(0, 12)];
            for (int i = 0; i < piece.len(); i++) chars.push_back(char_type'(piece[i]));
         end else if (r < 90) begin
            chars.push_back(char_type'($urandom_range(128, 255)));
         end else if (r < 93) begin
            chars.push_back('0);
         end else begin
            chars.push_back(char_type'($urandom_range(1, 127)));
         end
      end
      while (chars.size() > len) void'(chars.pop_back());
      if (!clean && len > 0 && $urandom_range(0, 99) < 10) chars[0] = ChDot;

      // the end may come as a separate transaction that carries no character
      marker = (len == 0) || ($urandom_range(0, 99) < 15);
      foreach (chars[i]) begin
         if ($urandom_range(0, 99) < 5)
            send_char(char_type'($urandom_range(0, 255)), 1'b0, 1'b0);  // ignored
         send_char(chars[i], 1'b1, !marker && i == len - 1);
      end
      if (marker) send_char(char_type'($urandom_range(0, 255)), 1'b0, 1'b1);
      name_count++;
   endtask

   function automatic int near_limit_len();
      int cap;
      int len;
      cap = (limit_now > MaxLenCap) ? MaxLenCap : limit_now;
      len = cap + $urandom_range(0, 2) - 1;
      return (len < 1) ? 1 : len;
   endfunction

   task automatic random_name();
      int r;
      r = $urandom_range(0, 99);
      if (r < 10) send_name(0, 1'b0);
      else if (r < 13 && limit_now <= 20) send_name(near_limit_len(), 1'b1);
      else if (r < 15 && limit_now <= 20) send_name(near_limit_len(), 1'b0);
      else send_name($urandom_range(1, 12), $urandom_range(0, 3) == 0);
   endtask

   // One register transfer, setup then access. The bus is left selected so
   // that a second transfer can follow at once; the caller releases it.
   task automatic csr_transfer(input bit wr, input char_type value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= wr;
      paddr   <= RegMaxNameLength;
      pwdata  <= CsrDataWidth'(value);
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
   endtask

   task automatic set_limit(input char_type value);
      csr_transfer(1'b1, value);
      csr_transfer(1'b0, '0);     // read back; the checker compares prdata
      psel    <= 1'b0;
      penable <= 1'b0;
      limit_now = value;
      limit_count++;
   endtask

   // Quiet the character side and wait until every verdict is in and the output has settled.
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (verdicts_due != 0);
      repeat (4) @(posedge clock);
   endtask

   initial begin
      char_type limits [8];
      int       gaps [8];
      int       phase_start;

      reset            = 1'b1;
      req_valid        = 1'b0;
      req_char_code    = '0;
      req_char_present = 1'b0;
      req_is_last      = 1'b0;
      psel             = 1'b0;
      penable          = 1'b0;
      pwrite           = 1'b0;
      paddr            = '0;
      pwdata           = '0;
      squeeze_go       = 1'b0;
      sent_count       = 0;
      name_count       = 0;
      limit_count      = 1;
      limit_now        = MaxLenReset;

      limits = '{MaxLenReset, 8'd1, MaxLenCap, 8'd0, MaxLenRaw,
                 char_type'($urandom_range(2, 60)), char_type'($urandom_range(2, 60)), 8'd3};
      gaps   = '{30, 0, 50, 20, 30, 60, 10, 40};

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset value of the length limit, read straight back
      csr_transfer(1'b0, '0);
      psel    <= 1'b0;
      penable <= 1'b0;

      // Directed names at the reset limit, back to back.
      gap_pct = 0;
      send_char(8'hFF, 1'b0, 1'b1);                         // empty name
      send_char(8'hFF, 1'b0, 1'b0);                         // ignored transaction
      send_char(ChUpZ, 1'b1, 1'b0);
      send_char(Ch9, 1'b1, 1'b1);                           // "Z9" safe
      send_char(Ch0, 1'b1, 1'b1);                           // "0" safe
      send_char(8'h00, 1'b1, 1'b1);                         // NUL byte
      send_char(8'hFF, 1'b1, 1'b1);                         // top byte
      send_char(8'h80, 1'b1, 1'b1);                         // first byte above 127
      send_char(ChDot, 1'b1, 1'b0);
      send_char(ChLowA, 1'b1, 1'b1);                        // leading dot
      send_char(ChLowA, 1'b1, 1'b0);
      send_char(ChDot, 1'b1, 1'b0);
      send_char(ChDot, 1'b1, 1'b1);                         // double dot
      send_char(ChLowX, 1'b1, 1'b0);
      send_char(ChDot, 1'b1, 1'b0);
      send_char(ChLowS, 1'b1, 1'b0);
      send_char(ChLowH, 1'b1, 1'b1);                        // ".sh" at the end
      send_char(ChLowZ, 1'b1, 1'b0);
      send_char(8'h00, 1'b0, 1'b1);                         // end after a character
      send_char(ChDash, 1'b1, 1'b0);
      send_char(ChUnder, 1'b1, 1'b1);                       // "-_" safe
      name_count += 11;

      // Random names under a series of length limits, extremes included.
      for (int p = 0; p < 8; p++) begin
         if (p > 0) begin
            drain();
            set_limit(limits[p]);
         end
         gap_pct = gaps[p];
         if (p == 0) squeeze_go = 1'b1;
         phase_start = sent_count;
         // 256 characters: the count saturates and the name stays too long
         if (limits[p] == MaxLenCap) send_name(256, 1'b1);
         else send_name(near_limit_len(), 1'b1);
         while (sent_count - phase_start < 75) random_name();
      end
      drain();

      $display("Run covered %0d character transactions in %0d names under %0d length limits,",
               sent_count, name_count, limit_count);
      $display("including a long verdict hold-off and names past the count saturation.");
      if (fail_count == 0) begin
         $display("filename_safety_checker_top_test passed");
      end else begin
         $display("filename_safety_checker_top_test failed");
      end
      $finish;
   end

endmodule
